// File: rtl/core/dur_pkg.sv
`timescale 1ns / 1ps
// dur_pkg: shared types, unit tables and constants for the duration string parser.
// No dependencies; imported by every dur_* module and the top level.
package dur_pkg;

    localparam int ACCUM_BITS_DEF = 40;
    localparam int QUEUE_DEPTH    = 2;
    localparam int S_TDATA_W      = 8;
    localparam int M_TDATA_W      = 56;
    localparam int DUR_W          = 51;
    localparam int TOTAL_W        = 33;
    localparam int LIM_W          = 31;
    localparam int SCALE_W        = 32;
    localparam int BASE_W         = 10;

    localparam logic [LIM_W-1:0]  LIM31   = '1;
    localparam logic [DUR_W-1:0]  OUT_MAX = '1;
    localparam logic [BASE_W-1:0] BASE_MS = 10'd1000;

    localparam logic [63:0] MS_PER_SEC = 64'd1000;
    localparam logic [63:0] LEN_YEAR   = 64'(60 * 60 * 24 * 365);
    localparam logic [63:0] LEN_MONTH  = 64'(60 * 60 * 24 * 30);
    localparam logic [63:0] LEN_WEEK   = 64'(60 * 60 * 24 * 7);
    localparam logic [63:0] LEN_DAY    = 64'(60 * 60 * 24);
    localparam logic [63:0] LEN_HOUR   = 64'(60 * 60);
    localparam logic [63:0] LEN_MIN    = 64'd60;
    localparam logic [63:0] LEN_SEC    = 64'd1;

    localparam logic [LIM_W-1:0] LIM_YEAR_S  = LIM_W'(64'(LIM31) / LEN_YEAR);
    localparam logic [LIM_W-1:0] LIM_MONTH_S = LIM_W'(64'(LIM31) / LEN_MONTH);
    localparam logic [LIM_W-1:0] LIM_WEEK_S  = LIM_W'(64'(LIM31) / LEN_WEEK);
    localparam logic [LIM_W-1:0] LIM_DAY_S   = LIM_W'(64'(LIM31) / LEN_DAY);
    localparam logic [LIM_W-1:0] LIM_HOUR_S  = LIM_W'(64'(LIM31) / LEN_HOUR);
    localparam logic [LIM_W-1:0] LIM_MIN_S   = LIM_W'(64'(LIM31) / LEN_MIN);
    localparam logic [LIM_W-1:0] LIM_SEC_S   = LIM_W'(64'(LIM31) / LEN_SEC);

    localparam logic [LIM_W-1:0] LIM_YEAR_M  = LIM_W'(64'(LIM31) / LEN_YEAR / MS_PER_SEC);
    localparam logic [LIM_W-1:0] LIM_MONTH_M = LIM_W'(64'(LIM31) / LEN_MONTH / MS_PER_SEC);
    localparam logic [LIM_W-1:0] LIM_WEEK_M  = LIM_W'(64'(LIM31) / LEN_WEEK / MS_PER_SEC);
    localparam logic [LIM_W-1:0] LIM_DAY_M   = LIM_W'(64'(LIM31) / LEN_DAY / MS_PER_SEC);
    localparam logic [LIM_W-1:0] LIM_HOUR_M  = LIM_W'(64'(LIM31) / LEN_HOUR / MS_PER_SEC);
    localparam logic [LIM_W-1:0] LIM_MIN_M   = LIM_W'(64'(LIM31) / LEN_MIN / MS_PER_SEC);
    localparam logic [LIM_W-1:0] LIM_SEC_M   = LIM_W'(64'(LIM31) / LEN_SEC / MS_PER_SEC);

    // scales only need to be exact mod 2^32: a product that passes its limit stays below 2^31
    localparam logic [SCALE_W-1:0] SCALE_YEAR_M  = SCALE_W'(LEN_YEAR * MS_PER_SEC);
    localparam logic [SCALE_W-1:0] SCALE_MONTH_M = SCALE_W'(LEN_MONTH * MS_PER_SEC);
    localparam logic [SCALE_W-1:0] SCALE_WEEK_M  = SCALE_W'(LEN_WEEK * MS_PER_SEC);
    localparam logic [SCALE_W-1:0] SCALE_DAY_M   = SCALE_W'(LEN_DAY * MS_PER_SEC);
    localparam logic [SCALE_W-1:0] SCALE_HOUR_M  = SCALE_W'(LEN_HOUR * MS_PER_SEC);
    localparam logic [SCALE_W-1:0] SCALE_MIN_M   = SCALE_W'(LEN_MIN * MS_PER_SEC);
    localparam logic [SCALE_W-1:0] SCALE_SEC_M   = SCALE_W'(LEN_SEC * MS_PER_SEC);

    typedef enum logic [3:0] {
        STEP_START = 4'd0,
        STEP_YEAR  = 4'd1,
        STEP_MONTH = 4'd2,
        STEP_WEEK  = 4'd3,
        STEP_DAY   = 4'd4,
        STEP_HOUR  = 4'd5,
        STEP_MIN   = 4'd6,
        STEP_SEC   = 4'd7,
        STEP_MSEC  = 4'd8,
        STEP_LAST  = 4'd9
    } step_t;

    typedef enum logic [3:0] {
        UNIT_YEAR,
        UNIT_MONTH,
        UNIT_WEEK,
        UNIT_DAY,
        UNIT_HOUR,
        UNIT_MIN,
        UNIT_SEC,
        UNIT_MSEC,
        UNIT_SPACE
    } unit_t;

    typedef enum logic [1:0] {
        TK_DIGIT,
        TK_UNIT,
        TK_MLETTER,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        unit_t       unit;
        logic [3:0]  digit;
        logic        last;
    } token_t;

    typedef struct packed {
        logic valid;
        logic err;
        logic sec_mode;
    } fin_ctrl_t;

    function automatic step_t unit_target(unit_t u);
        step_t s;
        case (u)
            UNIT_YEAR:  s = STEP_YEAR;
            UNIT_MONTH: s = STEP_MONTH;
            UNIT_WEEK:  s = STEP_WEEK;
            UNIT_DAY:   s = STEP_DAY;
            UNIT_HOUR:  s = STEP_HOUR;
            UNIT_MIN:   s = STEP_MIN;
            UNIT_SEC:   s = STEP_SEC;
            UNIT_MSEC:  s = STEP_MSEC;
            default:    s = STEP_LAST;
        endcase
        return s;
    endfunction

    // a unit is out of order once the step has reached this value
    function automatic step_t unit_floor(unit_t u);
        step_t s;
        case (u)
            UNIT_SPACE: s = STEP_SEC;
            default:    s = unit_target(u);
        endcase
        return s;
    endfunction

    function automatic logic [SCALE_W-1:0] unit_scale(unit_t u, logic sec_mode);
        logic [SCALE_W-1:0] v;
        case (u)
            UNIT_YEAR:  v = sec_mode ? SCALE_W'(LEN_YEAR)  : SCALE_YEAR_M;
            UNIT_MONTH: v = sec_mode ? SCALE_W'(LEN_MONTH) : SCALE_MONTH_M;
            UNIT_WEEK:  v = sec_mode ? SCALE_W'(LEN_WEEK)  : SCALE_WEEK_M;
            UNIT_DAY:   v = sec_mode ? SCALE_W'(LEN_DAY)   : SCALE_DAY_M;
            UNIT_HOUR:  v = sec_mode ? SCALE_W'(LEN_HOUR)  : SCALE_HOUR_M;
            UNIT_MIN:   v = sec_mode ? SCALE_W'(LEN_MIN)   : SCALE_MIN_M;
            UNIT_MSEC:  v = SCALE_W'(LEN_SEC);
            default:    v = sec_mode ? SCALE_W'(LEN_SEC)   : SCALE_SEC_M;
        endcase
        return v;
    endfunction

    function automatic logic [LIM_W-1:0] unit_limit(unit_t u, logic sec_mode);
        logic [LIM_W-1:0] v;
        case (u)
            UNIT_YEAR:  v = sec_mode ? LIM_YEAR_S  : LIM_YEAR_M;
            UNIT_MONTH: v = sec_mode ? LIM_MONTH_S : LIM_MONTH_M;
            UNIT_WEEK:  v = sec_mode ? LIM_WEEK_S  : LIM_WEEK_M;
            UNIT_DAY:   v = sec_mode ? LIM_DAY_S   : LIM_DAY_M;
            UNIT_HOUR:  v = sec_mode ? LIM_HOUR_S  : LIM_HOUR_M;
            UNIT_MIN:   v = sec_mode ? LIM_MIN_S   : LIM_MIN_M;
            UNIT_MSEC:  v = LIM31;
            default:    v = sec_mode ? LIM_SEC_S   : LIM_SEC_M;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/duration_string_parser.sv
`timescale 1ns / 1ps
// duration_string_parser: characters in, one duration per string out.
// m_axis_tvalid rises after the tlast token passes the queue, dur_exec, r1 and r2.
// Throughput: one character per cycle while s_axis_tready is high, set by dur_exec.
// Reset: seconds mode, parser state cleared, queue and result pipeline empty.
// Depends on dur_pkg, dur_front, dur_queue, dur_exec, dur_result.
module duration_string_parser
    import dur_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,    // seconds_mode
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] char_code
    input  logic                 s_axis_tlast,   // is_last
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [50:0] duration, [55:51] zero
    output logic                 m_axis_tuser    // parse_error
);

    logic                  q_ready, q_push, q_valid, q_pop;
    token_t                push_tok, head_tok;
    fin_ctrl_t             fin_ctrl;
    logic [TOTAL_W-1:0]    fin_tot;
    logic [ACCUM_BITS-1:0] fin_acc;
    logic                  fin_ready;
    logic [DUR_W-1:0]      m_dur;

    dur_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_tok         (push_tok)
    );

    dur_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_tok   (push_tok),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_tok   (head_tok)
    );

    dur_exec #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_tok       (head_tok),
        .q_pop       (q_pop),
        .fin_ctrl    (fin_ctrl),
        .fin_tot     (fin_tot),
        .fin_acc     (fin_acc),
        .fin_ready   (fin_ready)
    );

    dur_result #(
        .ACCUM_BITS (ACCUM_BITS)
    ) u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_ctrl  (fin_ctrl),
        .fin_tot   (fin_tot),
        .fin_acc   (fin_acc),
        .fin_ready (fin_ready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_dur     (m_dur),
        .m_err     (m_axis_tuser)
    );

    assign m_axis_tdata = M_TDATA_W'(m_dur);

endmodule

// File: rtl/core/dur_front.sv
`timescale 1ns / 1ps
// dur_front: accepts input characters and classifies each into a token.
// Depends on dur_pkg; feeds dur_queue.
module dur_front
    import dur_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] char_code
    input  logic                 s_axis_tlast,   // is_last
    input  logic                 q_ready,
    output logic                 q_push,
    output token_t               q_tok
);

    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_Y     = "y";
    localparam logic [7:0] CH_MON   = "M";
    localparam logic [7:0] CH_W     = "w";
    localparam logic [7:0] CH_D     = "d";
    localparam logic [7:0] CH_H     = "h";
    localparam logic [7:0] CH_M     = "m";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_SPACE = " ";

    logic [7:0] digit_off;

    assign s_axis_tready = q_ready;
    assign q_push        = s_axis_tvalid & q_ready;
    assign digit_off     = s_axis_tdata - CH_0;

    always_comb begin
        q_tok.kind  = TK_OTHER;
        q_tok.unit  = UNIT_SPACE;
        q_tok.digit = digit_off[3:0];
        q_tok.last  = s_axis_tlast;
        if (s_axis_tdata >= CH_0 && s_axis_tdata <= CH_9) begin
            q_tok.kind = TK_DIGIT;
        end else begin
            case (s_axis_tdata)
                CH_Y: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_YEAR;
                end
                CH_MON: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_MONTH;
                end
                CH_W: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_WEEK;
                end
                CH_D: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_DAY;
                end
                CH_H: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_HOUR;
                end
                CH_S: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_SEC;
                end
                CH_SPACE: begin
                    q_tok.kind = TK_UNIT;
                    q_tok.unit = UNIT_SPACE;
                end
                CH_M: begin
                    q_tok.kind = TK_MLETTER;
                end
                default: begin
                    q_tok.kind = TK_OTHER;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/dur_queue.sv
`timescale 1ns / 1ps
// dur_queue: short token queue between the classifier and the parse engine.
// Depends on dur_pkg.
module dur_queue
    import dur_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  token_t push_tok,
    output logic   push_ready,
    input  logic   pop,
    output logic   head_valid,
    output token_t head_tok
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    token_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_tok   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_END) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_END) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// File: rtl/core/dur_exec.sv
`timescale 1ns / 1ps
// dur_exec: parse engine; one token per cycle, stalled by fin_ready on a last token,
// updates acc, total and unit order. Uses dur_pkg; pops dur_queue, feeds dur_result.
module dur_exec
    import dur_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  q_valid,
    input  token_t                q_tok,
    output logic                  q_pop,
    output fin_ctrl_t             fin_ctrl,
    output logic [TOTAL_W-1:0]    fin_tot,
    output logic [ACCUM_BITS-1:0] fin_acc,
    input  logic                  fin_ready
);

    localparam int AW  = ACCUM_BITS;
    localparam int AXW = ACCUM_BITS + 4;

    logic                 mode_reg, mode_next;
    step_t                step_reg, step_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [TOTAL_W-1:0]   tot_reg, tot_next;
    logic                 seen_reg, seen_next;
    logic                 err_reg, err_next;
    logic                 pm_reg, pm_next;
    logic                 skip_reg, skip_next;

    // token-level next state, before restart handling
    step_t                step_tk;
    logic [AW-1:0]        acc_tk;
    logic [TOTAL_W-1:0]   tot_tk;
    logic                 seen_tk, err_tk, pm_tk, skip_tk;

    unit_t                prim_unit;
    logic [SCALE_W-1:0]   prim_scale;
    logic [LIM_W-1:0]     prim_limit;
    logic [SCALE_W-1:0]   prim_prod;
    logic [TOTAL_W:0]     prim_sum;
    logic                 prim_fail;
    logic                 is_s, is_space;
    logic [AXW-1:0]       acc_x10;
    logic [AW-1:0]        acc_dig;

    assign is_s     = (q_tok.kind == TK_UNIT) && (q_tok.unit == UNIT_SEC);
    assign is_space = (q_tok.kind == TK_UNIT) && (q_tok.unit == UNIT_SPACE);

    // the one unit close per token that can see a nonzero accumulator
    always_comb begin
        if (pm_reg) begin
            prim_unit = is_s ? UNIT_MSEC : UNIT_MIN;
        end else if (q_tok.kind == TK_UNIT) begin
            prim_unit = q_tok.unit;
        end else begin
            prim_unit = UNIT_MIN;
        end
    end

    assign prim_scale = unit_scale(prim_unit, mode_reg);
    assign prim_limit = unit_limit(prim_unit, mode_reg);
    assign prim_prod  = SCALE_W'(acc_reg[LIM_W-1:0]) * prim_scale;
    assign prim_sum   = (TOTAL_W+1)'(tot_reg) + (TOTAL_W+1)'(prim_prod);
    assign prim_fail  = (step_reg >= unit_floor(prim_unit))
                      || ((prim_unit == UNIT_MSEC) && mode_reg)
                      || (acc_reg > AW'(prim_limit))
                      || (prim_sum > (TOTAL_W+1)'(LIM31));

    assign acc_x10 = AXW'({acc_reg, 3'b000}) + AXW'({acc_reg, 1'b0}) + AXW'(q_tok.digit);
    assign acc_dig = (acc_x10[AXW-1:AW] != '0) ? '1 : acc_x10[AW-1:0];

    always_comb begin
        step_tk = step_reg;
        acc_tk  = acc_reg;
        tot_tk  = tot_reg;
        seen_tk = seen_reg;
        err_tk  = err_reg;
        pm_tk   = pm_reg;
        skip_tk = skip_reg;
        if (!err_reg) begin
            if (pm_reg) begin
                pm_tk = 1'b0;
                if (prim_fail) begin
                    err_tk = 1'b1;
                end else begin
                    step_tk = unit_target(prim_unit);
                    acc_tk  = '0;
                    tot_tk  = prim_sum[TOTAL_W-1:0];
                    skip_tk = 1'b1;
                    if (!is_s) begin
                        case (q_tok.kind)
                            TK_DIGIT: begin
                                acc_tk  = AW'(q_tok.digit);
                                seen_tk = 1'b1;
                                skip_tk = 1'b0;
                            end
                            TK_UNIT: begin
                                if (!is_space) begin
                                    err_tk = 1'b1;
                                end
                            end
                            TK_MLETTER: begin
                                skip_tk = 1'b0;
                                if (q_tok.last) begin
                                    err_tk = 1'b1;
                                end else begin
                                    pm_tk = 1'b1;
                                end
                            end
                            default: begin
                                err_tk = 1'b1;
                            end
                        endcase
                    end
                end
            end else if (!(skip_reg && is_space)) begin
                skip_tk = 1'b0;
                case (q_tok.kind)
                    TK_DIGIT: begin
                        acc_tk  = acc_dig;
                        seen_tk = 1'b1;
                    end
                    TK_UNIT, TK_MLETTER: begin
                        if (q_tok.kind == TK_MLETTER && !q_tok.last) begin
                            pm_tk = 1'b1;
                        end else if (prim_fail) begin
                            err_tk = 1'b1;
                        end else begin
                            step_tk = unit_target(prim_unit);
                            acc_tk  = '0;
                            tot_tk  = prim_sum[TOTAL_W-1:0];
                            skip_tk = 1'b1;
                        end
                    end
                    default: begin
                        err_tk = 1'b1;
                    end
                endcase
            end
        end
    end

    assign q_pop          = q_valid && (!q_tok.last || fin_ready);
    assign fin_ctrl.valid = q_valid && q_tok.last;
    assign fin_ctrl.err   = err_tk || !seen_tk;
    assign fin_ctrl.sec_mode = mode_reg;
    assign fin_tot        = tot_tk;
    assign fin_acc        = acc_tk;

    always_comb begin
        mode_next = mode_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        tot_next  = tot_reg;
        seen_next = seen_reg;
        err_next  = err_reg;
        pm_next   = pm_reg;
        skip_next = skip_reg;
        if (cfg_wr_en || (q_pop && q_tok.last)) begin
            mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;
            step_next = mode_next ? STEP_START : STEP_MONTH;
            acc_next  = '0;
            tot_next  = '0;
            seen_next = 1'b0;
            err_next  = 1'b0;
            pm_next   = 1'b0;
            skip_next = 1'b0;
        end else if (q_pop) begin
            step_next = step_tk;
            acc_next  = acc_tk;
            tot_next  = tot_tk;
            seen_next = seen_tk;
            err_next  = err_tk;
            pm_next   = pm_tk;
            skip_next = skip_tk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            step_reg <= STEP_START;
            acc_reg  <= '0;
            tot_reg  <= '0;
            seen_reg <= 1'b0;
            err_reg  <= 1'b0;
            pm_reg   <= 1'b0;
            skip_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            step_reg <= step_next;
            acc_reg  <= acc_next;
            tot_reg  <= tot_next;
            seen_reg <= seen_next;
            err_reg  <= err_next;
            pm_reg   <= pm_next;
            skip_reg <= skip_next;
        end
    end

endmodule

// File: rtl/core/dur_result.sv
`timescale 1ns / 1ps
// dur_result: two-stage result pipeline; scales trailing digits, adds, saturates; zero on error.
// Depends on dur_pkg; drives the m_axis output register.
module dur_result
    import dur_pkg::*;
#(
    parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fin_ctrl_t             fin_ctrl,
    input  logic [TOTAL_W-1:0]    fin_tot,
    input  logic [ACCUM_BITS-1:0] fin_acc,
    output logic                  fin_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUR_W-1:0]      m_dur,
    output logic                  m_err
);

    localparam int PW = ACCUM_BITS + BASE_W;
    localparam int SW = (PW + 1 > DUR_W + 1) ? PW + 1 : DUR_W + 1;

    logic                r1_valid_reg, r1_valid_next;
    logic [PW-1:0]       r1_prod_reg;
    logic [TOTAL_W-1:0]  r1_tot_reg;
    logic                r1_err_reg;
    logic                r2_valid_reg, r2_valid_next;
    logic [DUR_W-1:0]    r2_dur_reg, r2_dur_next;
    logic                r2_err_reg;
    logic                r1_load, r2_load;
    logic [PW-1:0]       prod_next;
    logic [SW-1:0]       sum;

    assign r2_load   = !r2_valid_reg || m_ready;
    assign fin_ready = !r1_valid_reg || r2_load;
    assign r1_load   = fin_ctrl.valid && fin_ready;

    assign prod_next = fin_ctrl.sec_mode ? PW'(fin_acc) : PW'(fin_acc) * PW'(BASE_MS);
    assign sum       = SW'(r1_prod_reg) + SW'(r1_tot_reg);

    always_comb begin
        if (r1_err_reg) begin
            r2_dur_next = '0;
        end else if (sum > SW'(OUT_MAX)) begin
            r2_dur_next = OUT_MAX;
        end else begin
            r2_dur_next = sum[DUR_W-1:0];
        end
    end

    always_comb begin
        r1_valid_next = r1_valid_reg;
        if (r1_load) begin
            r1_valid_next = 1'b1;
        end else if (r2_load) begin
            r1_valid_next = 1'b0;
        end
        r2_valid_next = r2_load ? r1_valid_reg : r2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
        end else begin
            r1_valid_reg <= r1_valid_next;
            r2_valid_reg <= r2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1_load) begin
            r1_prod_reg <= prod_next;
            r1_tot_reg  <= fin_tot;
            r1_err_reg  <= fin_ctrl.err;
        end
        if (r2_load && r1_valid_reg) begin
            r2_dur_reg <= r2_dur_next;
            r2_err_reg <= r1_err_reg;
        end
    end

    assign m_valid = r2_valid_reg;
    assign m_dur   = r2_dur_reg;
    assign m_err   = r2_err_reg;

endmodule
